### rtl/core/arm64_subset_instruction_executor_defines.svh
// assertion helpers used by the top-level core file
`ifndef ARM64_SUBSET_INSTRUCTION_EXECUTOR_DEFINES_SVH
`define ARM64_SUBSET_INSTRUCTION_EXECUTOR_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define A64X_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define A64X_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/a64x_pkg.sv
package a64x_pkg;

   localparam int unsigned XLEN     = 64;
   localparam int unsigned NUM_REGS = 32;
   localparam int unsigned REG_AW   = 5;

   // 11-bit major opcodes, instruction bits 31:21
   localparam logic [10:0] OP11_ADD_REG  = 11'b10001011001;
   localparam logic [10:0] OP11_ADDS_REG = 11'b10101011000;
   localparam logic [10:0] OP11_SUBS_REG = 11'b11101011000;
   localparam logic [10:0] OP11_ANDS_REG = 11'b11101010000;
   localparam logic [10:0] OP11_EOR_REG  = 11'b11001010000;
   localparam logic [10:0] OP11_ORR_REG  = 11'b10101010000;
   localparam logic [10:0] OP11_BR       = 11'b11010110000;
   localparam logic [10:0] OP11_HLT      = 11'b11010100010;
   localparam logic [10:0] OP11_STUR     = 11'b11111000000;
   localparam logic [10:0] OP11_STURB    = 11'b00111000000;
   localparam logic [10:0] OP11_STURH    = 11'b01111000000;

   // 8-bit opcodes, instruction bits 31:24
   localparam logic [7:0] OP8_ADD_IMM  = 8'b10010001;
   localparam logic [7:0] OP8_ADDS_IMM = 8'b10110001;
   localparam logic [7:0] OP8_SUBS_IMM = 8'b11110001;
   localparam logic [7:0] OP8_BCOND    = 8'b01010100;

   // 6-bit opcode, instruction bits 31:26
   localparam logic [5:0] OP6_B = 6'b000101;

   // branch condition codes
   localparam logic [3:0] COND_EQ = 4'h0;
   localparam logic [3:0] COND_NE = 4'h1;
   localparam logic [3:0] COND_GE = 4'hA;
   localparam logic [3:0] COND_LT = 4'hB;
   localparam logic [3:0] COND_GT = 4'hC;
   localparam logic [3:0] COND_LE = 4'hD;

   localparam logic [REG_AW-1:0] ZERO_REG = 5'd31;

   // state changes and result of one executed instruction
   typedef struct packed {
      logic              wr_en;
      logic [REG_AW-1:0] wr_addr;
      logic [XLEN-1:0]   wr_data;
      logic              flag_en;
      logic              flag_n;
      logic              flag_z;
      logic              halted;
      logic              store_en;
      logic [XLEN-1:0]   store_addr;
      logic [31:0]       store_data;
      logic [XLEN-1:0]   next_pc;
   } exec_type;

   // stores read rt on the second port instead of rm
   function automatic logic is_store(input logic [10:0] op11);
      logic hit;
      hit = (op11 == OP11_STUR) || (op11 == OP11_STURB) || (op11 == OP11_STURH);
      return hit;
   endfunction

endpackage

### rtl/core/a64x_chan_if.sv
interface a64x_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] instruction_word;

   modport source (output valid, output instruction_word, input ready);
   modport sink (input valid, input instruction_word, output ready);
endinterface

interface a64x_rsp_if;
   logic        valid;
   logic        ready;
   logic        store_enable;
   logic [63:0] store_address;
   logic [31:0] store_data;
   logic [63:0] next_pc;
   logic        halted;

   modport source (output valid, output store_enable, output store_address,
                   output store_data, output next_pc, output halted, input ready);
   modport sink (input valid, input store_enable, input store_address,
                 input store_data, input next_pc, input halted, output ready);
endinterface

### rtl/core/a64x_regfile.sv
module a64x_regfile (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           rd_en,
   input  logic [a64x_pkg::REG_AW-1:0]    rd_addr_a,
   input  logic [a64x_pkg::REG_AW-1:0]    rd_addr_b,
   output logic [a64x_pkg::XLEN-1:0]      rd_data_a,
   output logic [a64x_pkg::XLEN-1:0]      rd_data_b,
   input  logic                           wr_en,
   input  logic [a64x_pkg::REG_AW-1:0]    wr_addr,
   input  logic [a64x_pkg::XLEN-1:0]      wr_data
);

   logic [a64x_pkg::XLEN-1:0]     mem_ff [a64x_pkg::NUM_REGS];
   logic [a64x_pkg::NUM_REGS-1:0] valid_ff;
   logic [a64x_pkg::XLEN-1:0]     data_a_ff;
   logic [a64x_pkg::XLEN-1:0]     data_b_ff;

   // entries never written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered reads, write in the same cycle passes through
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr_a)) begin
            data_a_ff <= wr_data;
         end else begin
            data_a_ff <= valid_ff[rd_addr_a] ? mem_ff[rd_addr_a] : '0;
         end
         if (wr_en && (wr_addr == rd_addr_b)) begin
            data_b_ff <= wr_data;
         end else begin
            data_b_ff <= valid_ff[rd_addr_b] ? mem_ff[rd_addr_b] : '0;
         end
      end
   end

   assign rd_data_a = data_a_ff;
   assign rd_data_b = data_b_ff;

endmodule

### rtl/core/a64x_exec.sv
module a64x_exec (
   input  logic [31:0]                 instr,
   input  logic [a64x_pkg::XLEN-1:0]   op_a,
   input  logic [a64x_pkg::XLEN-1:0]   op_b,
   input  logic [a64x_pkg::XLEN-1:0]   pc,
   input  logic                        flag_n,
   input  logic                        flag_z,
   input  logic                        stopped,
   output a64x_pkg::exec_type          res
);

   logic [10:0]               op11;
   logic [7:0]                op8;
   logic [5:0]                op6;
   logic [a64x_pkg::XLEN-1:0] imm;
   logic [a64x_pkg::XLEN-1:0] pc_plus4;
   logic [a64x_pkg::XLEN-1:0] bcond_target;
   logic [a64x_pkg::XLEN-1:0] b_target;
   logic [a64x_pkg::XLEN-1:0] st_addr;
   logic [a64x_pkg::XLEN-1:0] value;
   logic                      cond_ok;
   logic                      do_write;
   logic                      do_flags;

   assign op11 = instr[31:21];
   assign op8  = instr[31:24];
   assign op6  = instr[31:26];

   // shift code 1 moves imm12 up by 12, others unshifted
   assign imm = (instr[23:22] == 2'b01) ? {40'd0, instr[21:10], 12'd0}
                                        : {52'd0, instr[21:10]};

   assign pc_plus4     = pc + 64'd4;
   assign bcond_target = pc + {{43{instr[23]}}, instr[23:5], 2'b00};
   assign b_target     = pc + {{36{instr[25]}}, instr[25:0], 2'b00};
   assign st_addr      = op_a + {{55{instr[20]}}, instr[20:12]};

   always_comb begin
      unique case (instr[3:0])
         a64x_pkg::COND_EQ: cond_ok = flag_z;
         a64x_pkg::COND_NE: cond_ok = !flag_z;
         a64x_pkg::COND_GE: cond_ok = !flag_n || flag_z;
         a64x_pkg::COND_LT: cond_ok = flag_n && !flag_z;
         a64x_pkg::COND_GT: cond_ok = !flag_n && !flag_z;
         a64x_pkg::COND_LE: cond_ok = flag_n || flag_z;
         default:           cond_ok = 1'b0;
      endcase
   end

   always_comb begin
      value          = '0;
      do_write       = 1'b0;
      do_flags       = 1'b0;
      res            = '0;
      res.next_pc    = pc_plus4;

      unique case (op11)
         a64x_pkg::OP11_ADD_REG: begin
            value    = op_a + op_b;
            do_write = 1'b1;
         end
         a64x_pkg::OP11_ADDS_REG: begin
            value    = op_a + op_b;
            do_write = 1'b1;
            do_flags = 1'b1;
         end
         a64x_pkg::OP11_SUBS_REG: begin
            value    = op_a - op_b;
            do_write = 1'b1;
            do_flags = 1'b1;
         end
         a64x_pkg::OP11_ANDS_REG: begin
            value    = op_a & op_b;
            do_write = 1'b1;
            do_flags = 1'b1;
         end
         a64x_pkg::OP11_EOR_REG: begin
            value    = op_a ^ op_b;
            do_write = 1'b1;
         end
         a64x_pkg::OP11_ORR_REG: begin
            value    = op_a | op_b;
            do_write = 1'b1;
         end
         a64x_pkg::OP11_BR: begin
            res.next_pc = op_a;
         end
         a64x_pkg::OP11_HLT: begin
            res.halted = 1'b1;
         end
         a64x_pkg::OP11_STUR: begin
            res.store_en   = 1'b1;
            res.store_addr = st_addr;
            res.store_data = op_b[31:0];
         end
         a64x_pkg::OP11_STURB: begin
            res.store_en   = 1'b1;
            res.store_addr = st_addr;
            res.store_data = {24'd0, op_b[7:0]};
         end
         a64x_pkg::OP11_STURH: begin
            res.store_en   = 1'b1;
            res.store_addr = {st_addr[63:2], 2'b00};
            res.store_data = {16'd0, op_b[15:0]};
         end
         default: begin
            unique case (op8)
               a64x_pkg::OP8_ADD_IMM: begin
                  value    = op_a + imm;
                  do_write = 1'b1;
               end
               a64x_pkg::OP8_ADDS_IMM: begin
                  value    = op_a + imm;
                  do_write = 1'b1;
                  do_flags = 1'b1;
               end
               a64x_pkg::OP8_SUBS_IMM: begin
                  value    = op_a - imm;
                  do_write = 1'b1;
                  do_flags = 1'b1;
               end
               a64x_pkg::OP8_BCOND: begin
                  if (cond_ok) begin
                     res.next_pc = bcond_target;
                  end
               end
               default: begin
                  if (op6 == a64x_pkg::OP6_B) begin
                     res.next_pc = b_target;
                  end
               end
            endcase
         end
      endcase

      res.wr_en   = do_write && (instr[4:0] != a64x_pkg::ZERO_REG);
      res.wr_addr = instr[4:0];
      res.wr_data = value;
      res.flag_en = do_flags;
      res.flag_n  = value[63];
      res.flag_z  = (value == '0);

      // a stopped machine ignores the word and holds its pc
      if (stopped) begin
         res         = '0;
         res.next_pc = pc;
         res.halted  = 1'b1;
      end
   end

endmodule

### rtl/core/arm64_subset_instruction_executor.sv
// A64 subset executor: each transfer on req_if carries one 32-bit instruction
// fetched at the current pc, and each instruction yields exactly one transfer
// on rsp_if with the store request it makes (store_enable, address, data), the
// pc after it and the halted state; results come back in order. The block
// holds 32 x 64-bit registers (x31 reads zero, writes to it are dropped), the
// N and Z flags and the pc, all zero after reset. One instruction is taken per
// clock while the result side drains: at the req_if transfer edge the input
// stage captures the word together with its two register operands (a write
// made at that same edge is bypassed into the read), and the execute logic
// works on it once the result register is free or being drained and loads
// the result register, which drives rsp_if valid. A new word can follow every
// cycle while rsp_if is not stalled. The input side keeps taking words while a
// result waits on rsp_if, until the input stage itself is full. After HLT
// every further word is ignored and answered with the held pc and halted set.
`include "arm64_subset_instruction_executor_defines.svh"

module arm64_subset_instruction_executor (
   input logic         clock,
   input logic         reset,
   a64x_req_if.sink    req_if,
   a64x_rsp_if.source  rsp_if
);

   // input stage
   logic                      in_valid_ff;
   logic                      in_valid_in;
   logic [31:0]               word_ff;
   logic                      req_xfer;
   logic                      exec_fire;

   // architectural state
   logic [a64x_pkg::XLEN-1:0] pc_ff;
   logic                      flag_n_ff;
   logic                      flag_z_ff;
   logic                      stopped_ff;

   // register file read data for the word in the input stage
   logic [a64x_pkg::XLEN-1:0] op_a;
   logic [a64x_pkg::XLEN-1:0] op_b;
   logic [a64x_pkg::REG_AW-1:0] addr_b;

   a64x_pkg::exec_type        ex;

   // result register
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic                      store_enable_ff;
   logic [63:0]               store_address_ff;
   logic [31:0]               store_data_ff;
   logic [63:0]               next_pc_ff;
   logic                      halted_ff;

   // execute when the result register is free or being drained
   assign exec_fire = in_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || exec_fire;
   assign req_xfer = req_if.valid && req_if.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (exec_fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         word_ff <= req_if.instruction_word;
      end
   end

   // stores read rt on the second port, everything else reads rm
   assign addr_b = a64x_pkg::is_store(req_if.instruction_word[31:21])
                   ? req_if.instruction_word[4:0]
                   : req_if.instruction_word[20:16];

   a64x_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (req_xfer),
      .rd_addr_a (req_if.instruction_word[9:5]),
      .rd_addr_b (addr_b),
      .rd_data_a (op_a),
      .rd_data_b (op_b),
      .wr_en     (exec_fire && ex.wr_en),
      .wr_addr   (ex.wr_addr),
      .wr_data   (ex.wr_data)
   );

   a64x_exec u_exec (
      .instr   (word_ff),
      .op_a    (op_a),
      .op_b    (op_b),
      .pc      (pc_ff),
      .flag_n  (flag_n_ff),
      .flag_z  (flag_z_ff),
      .stopped (stopped_ff),
      .res     (ex)
   );

   // pc, flags and halt state move only when an instruction executes
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff      <= '0;
         flag_n_ff  <= 1'b0;
         flag_z_ff  <= 1'b0;
         stopped_ff <= 1'b0;
      end else if (exec_fire) begin
         pc_ff      <= ex.next_pc;
         stopped_ff <= ex.halted;
         if (ex.flag_en) begin
            flag_n_ff <= ex.flag_n;
            flag_z_ff <= ex.flag_z;
         end
      end
   end

   // result register, held until the rsp transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (exec_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_fire) begin
         store_enable_ff  <= ex.store_en;
         store_address_ff <= ex.store_addr;
         store_data_ff    <= ex.store_data;
         next_pc_ff       <= ex.next_pc;
         halted_ff        <= ex.halted;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.store_enable  = store_enable_ff;
   assign rsp_if.store_address = store_address_ff;
   assign rsp_if.store_data    = store_data_ff;
   assign rsp_if.next_pc       = next_pc_ff;
   assign rsp_if.halted        = halted_ff;

   // halt is sticky until reset
   `A64X_ASSERT_NEXT(a_stop_sticky, stopped_ff, stopped_ff, "halt state cleared")
   // an executed instruction always lands in the result register
   `A64X_ASSERT_NEXT(a_exec_lands, exec_fire, rsp_valid_ff, "result lost")
   // no store once halted
   `A64X_ASSERT_IMP(a_no_store_halted, rsp_valid_ff && halted_ff, !store_enable_ff,
                    "store while halted")
   // non-store results carry zero address and data
   `A64X_ASSERT_IMP(a_idle_store_zero, rsp_valid_ff && !store_enable_ff,
                    (store_address_ff == '0) && (store_data_ff == '0),
                    "store payload without store")

endmodule

### bench/a64x_exec_checker.sv
module a64x_exec_checker
   import a64x_pkg::*;
(
   input  logic clock,
   input  logic reset,
   a64x_req_if  req_ch,
   a64x_rsp_if  rsp_ch,
   output int   pending,
   output int   fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic        store_enable;
      logic [63:0] store_address;
      logic [31:0] store_data;
      logic [63:0] next_pc;
      logic        halted;
   } retire_type;

   // architectural state as the block should hold it
   logic [63:0] gpr [NUM_REGS];
   logic [63:0] pc_q;
   logic        neg_q;
   logic        zero_q;
   logic        halted_q;

   retire_type retire_q [$];
   int         fails = 0;

   assign fail_count = fails;

   function automatic logic cond_met(input logic [3:0] c);
      case (c)
         COND_EQ: return zero_q;
         COND_NE: return !zero_q;
         COND_GE: return !neg_q || zero_q;
         COND_LT: return neg_q && !zero_q;
         COND_GT: return !neg_q && !zero_q;
         COND_LE: return neg_q || zero_q;
         default: return 1'b0;
      endcase
   endfunction

   // executes one word on the local state and returns what should retire
   function automatic retire_type execute_word(input logic [31:0] w);
      retire_type  res;
      logic [4:0]  rd;
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] imm;
      logic [63:0] val;
      logic [63:0] npc;
      logic        wen;
      logic        fen;
      res = '0;
      if (halted_q) begin
         res.next_pc = pc_q;
         res.halted  = 1'b1;
         return res;
      end
      rd  = w[4:0];
      a   = gpr[w[9:5]];
      b   = gpr[w[20:16]];
      npc = pc_q + 64'd4;
      imm = {52'd0, w[21:10]};
      if (w[23:22] == 2'b01) imm = imm << 12;
      wen = 1'b0;
      fen = 1'b0;
      val = '0;
      case (w[31:21])
         OP11_ADD_REG: begin
            wen = 1'b1;
            val = a + b;
         end
         OP11_ADDS_REG: begin
            wen = 1'b1;
            fen = 1'b1;
            val = a + b;
         end
         OP11_SUBS_REG: begin
            wen = 1'b1;
            fen = 1'b1;
            val = a - b;
         end
         OP11_ANDS_REG: begin
            wen = 1'b1;
            fen = 1'b1;
            val = a & b;
         end
         OP11_EOR_REG: begin
            wen = 1'b1;
            val = a ^ b;
         end
         OP11_ORR_REG: begin
            wen = 1'b1;
            val = a | b;
         end
         OP11_BR: npc = a;
         OP11_HLT: halted_q = 1'b1;
         OP11_STUR, OP11_STURB, OP11_STURH: begin
            res.store_enable  = 1'b1;
            res.store_address = a + {{55{w[20]}}, w[20:12]};
            res.store_data    = gpr[rd][31:0];
            if (w[31:21] == OP11_STURB) begin
               res.store_data = {24'd0, res.store_data[7:0]};
            end else if (w[31:21] == OP11_STURH) begin
               res.store_data = {16'd0, res.store_data[15:0]};
               res.store_address[1:0] = 2'b00;
            end
         end
         default: begin
            case (w[31:24])
               OP8_ADD_IMM: begin
                  wen = 1'b1;
                  val = a + imm;
               end
               OP8_ADDS_IMM: begin
                  wen = 1'b1;
                  fen = 1'b1;
                  val = a + imm;
               end
               OP8_SUBS_IMM: begin
                  wen = 1'b1;
                  fen = 1'b1;
                  val = a - imm;
               end
               OP8_BCOND: begin
                  if (cond_met(w[3:0])) npc = pc_q + {{43{w[23]}}, w[23:5], 2'b00};
               end
               default: begin
                  if (w[31:26] == OP6_B) npc = pc_q + {{36{w[25]}}, w[25:0], 2'b00};
               end
            endcase
         end
      endcase
      // x31 is never written, so it keeps reading zero
      if (wen && rd != ZERO_REG) gpr[rd] = val;
      if (fen) begin
         neg_q  = val[63];
         zero_q = (val == '0);
      end
      pc_q        = npc;
      res.next_pc = npc;
      res.halted  = halted_q;
      return res;
   endfunction

   task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", name, want, got);
         fails++;
      end
   endtask

   always @(posedge clock) begin : watch
      retire_type got;
      retire_type want;
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) gpr[i] = '0;
         pc_q     = '0;
         neg_q    = 1'b0;
         zero_q   = 1'b0;
         halted_q = 1'b0;
         retire_q.delete();
      end else begin
         if (req_ch.valid && req_ch.ready)
            retire_q.push_back(execute_word(req_ch.instruction_word));
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.store_enable, rsp_ch.store_address, rsp_ch.store_data,
                    rsp_ch.next_pc, rsp_ch.halted};
            if (retire_q.size() == 0) begin
               $error("result transfer with no instruction pending");
               fails++;
            end else begin
               want = retire_q.pop_front();
               check_field("store_enable", want.store_enable, got.store_enable);
               check_field("store_address", want.store_address, got.store_address);
               check_field("store_data", want.store_data, got.store_data);
               check_field("next_pc", want.next_pc, got.next_pc);
               check_field("halted", want.halted, got.halted);
            end
         end
      end
      pending <= retire_q.size();
   end

endmodule

### bench/tb_top.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import a64x_pkg::*;

   // condition code outside the supported set, never taken here
   localparam logic [3:0] COND_AL = 4'hE;
   localparam int unsigned RANDOM_WORDS = 1400;

   logic clock = 1'b0;
   logic reset;
   bit   calm;       // set during the stretch with no random gaps or stalls on either side
   int   pending;
   int   fail_count;

   a64x_req_if req_ch ();
   a64x_rsp_if rsp_ch ();

   arm64_subset_instruction_executor DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   a64x_exec_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .pending    (pending),
      .fail_count (fail_count)
   );

   always #2 clock = ~clock;

   // result side back-pressure, ready withheld with a chance of one in five
   always @(posedge clock) begin
      rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 20);
   end

   // instruction encoders, don't-care bits filled at random
   function automatic logic [31:0] enc_reg(input logic [10:0] op, input logic [4:0] rm,
                                           input logic [4:0] rn, input logic [4:0] rd);
      return {op, rm, 6'($urandom), rn, rd};
   endfunction

   function automatic logic [31:0] enc_imm(input logic [7:0] op, input logic [1:0] sh,
                                           input logic [11:0] imm12, input logic [4:0] rn,
                                           input logic [4:0] rd);
      return {op, sh, imm12, rn, rd};
   endfunction

   function automatic logic [31:0] enc_store(input logic [10:0] op, input logic [8:0] imm9,
                                             input logic [4:0] rn, input logic [4:0] rt);
      return {op, imm9, 2'($urandom), rn, rt};
   endfunction

   function automatic logic [31:0] enc_bcond(input logic [18:0] imm19, input logic [3:0] c);
      return {OP8_BCOND, imm19, 1'($urandom), c};
   endfunction

   function automatic logic [31:0] enc_b(input logic [25:0] imm26);
      return {OP6_B, imm26};
   endfunction

   function automatic logic [31:0] enc_br(input logic [4:0] rn);
      return {OP11_BR, 11'($urandom), rn, 5'($urandom)};
   endfunction

   // mostly a small working set so values build up, plus x31 and the full range
   function automatic logic [4:0] pick_reg();
      int r;
      r = $urandom_range(0, 15);
      if (r == 0) return ZERO_REG;
      if (r == 1) return 5'($urandom);
      return 5'($urandom_range(0, 7));
   endfunction

   // one random instruction, never a halt, since that would stop the machine for good
   function automatic logic [31:0] random_word();
      int          pick;
      logic [10:0] op;
      logic [7:0]  op8;
      logic [3:0]  c;
      logic [31:0] w;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         // noise, mostly unknown encodings
         do w = $urandom; while (w[31:21] == OP11_HLT);
         return w;
      end else if (pick < 36) begin
         case ($urandom_range(0, 5))
            0:       op = OP11_ADD_REG;
            1:       op = OP11_ADDS_REG;
            2:       op = OP11_SUBS_REG;
            3:       op = OP11_ANDS_REG;
            4:       op = OP11_EOR_REG;
            default: op = OP11_ORR_REG;
         endcase
         return enc_reg(op, pick_reg(), pick_reg(), pick_reg());
      end else if (pick < 56) begin
         case ($urandom_range(0, 2))
            0:       op8 = OP8_ADD_IMM;
            1:       op8 = OP8_ADDS_IMM;
            default: op8 = OP8_SUBS_IMM;
         endcase
         return enc_imm(op8, 2'($urandom),
                        ($urandom_range(0, 3) == 0) ? 12'($urandom)
                                                    : 12'($urandom_range(0, 15)),
                        pick_reg(), pick_reg());
      end else if (pick < 70) begin
         case ($urandom_range(0, 6))
            0:       c = COND_EQ;
            1:       c = COND_NE;
            2:       c = COND_GE;
            3:       c = COND_LT;
            4:       c = COND_GT;
            5:       c = COND_LE;
            default: c = 4'($urandom);
         endcase
         return enc_bcond(19'($urandom), c);
      end else if (pick < 75) begin
         return enc_b(26'($urandom));
      end else if (pick < 80) begin
         return enc_br(pick_reg());
      end
      case ($urandom_range(0, 2))
         0:       op = OP11_STUR;
         1:       op = OP11_STURB;
         default: op = OP11_STURH;
      endcase
      return enc_store(op, 9'($urandom), pick_reg(), pick_reg());
   endfunction

   // hold the word until the transfer, then sometimes leave a random gap
   task automatic issue_word(input logic [31:0] w);
      req_ch.valid <= 1'b1;
      req_ch.instruction_word <= w;
      do @(posedge clock); while (!req_ch.ready);
      if (!calm && $urandom_range(0, 99) < 10) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // stop sending until every result is back
   task automatic drain_all();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   initial begin
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.instruction_word <= '0;
      calm = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // immediates: largest imm12, shift by 12, shift codes 2 and 3 unshifted
      issue_word(enc_imm(OP8_ADD_IMM, 2'd0, 12'hFFF, ZERO_REG, 5'd1));
      issue_word(enc_imm(OP8_ADD_IMM, 2'd1, 12'hFFF, 5'd1, 5'd2));
      issue_word(enc_imm(OP8_ADDS_IMM, 2'd2, 12'h800, 5'd2, 5'd3));
      // zero minus one gives all ones and sets n
      issue_word(enc_imm(OP8_SUBS_IMM, 2'd3, 12'h001, ZERO_REG, 5'd4));
      // lt taken with the most negative offset, ge not taken
      issue_word(enc_bcond(19'h40000, COND_LT));
      issue_word(enc_bcond(19'h00001, COND_GE));
      issue_word(enc_reg(OP11_ADDS_REG, 5'd4, 5'd4, 5'd5));
      // equal operands set z, destination x31 dropped
      issue_word(enc_reg(OP11_SUBS_REG, 5'd4, 5'd4, ZERO_REG));
      issue_word(enc_bcond(19'h3FFFF, COND_EQ));
      issue_word(enc_bcond(19'h00010, COND_LE));
      issue_word(enc_bcond(19'h00020, COND_NE));
      // unsupported condition never branches
      issue_word(enc_bcond(19'h00040, COND_AL));
      issue_word(enc_reg(OP11_ANDS_REG, 5'd2, 5'd4, 5'd6));
      issue_word(enc_bcond(19'h00003, COND_GT));
      issue_word(enc_reg(OP11_EOR_REG, 5'd2, 5'd4, 5'd7));
      issue_word(enc_reg(OP11_ORR_REG, 5'd1, 5'd7, 5'd8));
      issue_word(enc_reg(OP11_ADD_REG, ZERO_REG, 5'd8, 5'd9));
      // stores: most negative offset, byte at x31 base, halfword aligned down
      issue_word(enc_store(OP11_STUR, 9'h100, 5'd2, 5'd4));
      issue_word(enc_store(OP11_STURB, 9'h0FF, ZERO_REG, 5'd2));
      issue_word(enc_store(OP11_STURH, 9'h003, 5'd1, 5'd4));
      // register branch to all ones, then far jumps both ways
      issue_word(enc_br(5'd4));
      issue_word(enc_b(26'h1FFFFFF));
      issue_word(enc_b(26'h2000000));
      // unknown words only advance the pc
      issue_word(32'h0000_0000);
      issue_word(32'hFFFF_FFFF);
      issue_word(enc_reg(OP11_ADDS_REG, 5'd1, 5'd4, ZERO_REG));
      drain_all();

      for (int i = 0; i < RANDOM_WORDS; i++) begin
         calm = (i >= 500 && i < 800);
         if (i == 700) drain_all();
         issue_word(random_word());
      end
      calm = 1'b0;

      // halt, then words that must be ignored
      issue_word({OP11_HLT, 21'($urandom)});
      issue_word(random_word());
      issue_word(enc_store(OP11_STUR, 9'h010, 5'd1, 5'd4));
      issue_word(32'hFFFF_FFFF);

      drain_all();
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

   // hard stop far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("tb_top NOT OK");
      $finish;
   end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/a64x_pkg.sv
rtl/core/a64x_chan_if.sv
rtl/core/a64x_regfile.sv
rtl/core/a64x_exec.sv
rtl/core/arm64_subset_instruction_executor.sv
bench/a64x_exec_checker.sv
bench/tb_top.sv
